// File: hw/rtl/kwhm_pkg.sv
// Shared constants, command codes and controller/datapath structs of the heap merger.
package kwhm_pkg;

  localparam int unsigned MAX_LISTS_DEF = 64;
  localparam int unsigned MAX_ITEMS_DEF = 1024;
  localparam int unsigned VAL_W = 32;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_OPEN   = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  typedef struct packed {
    logic load;
    logic start;
    logic build_rd;
    logic build_cap;
    logic root_rd;
    logic root_cap;
    logic ptr_step;
    logic key_cap;
    logic last_cap;
    logic sift_rd_l;
    logic sift_cap_l;
    logic sift_cap_r;
    logic sift_wr;
    logic res_load;
  } kwhm_ctl_t;

  typedef struct packed {
    logic merging;
    logic fill_zero;
    logic build_done;
    logic list_empty;
    logic pos_out;
    logic leaf;
    logic no_right;
    logic best_is_pos;
    logic out_free;
  } kwhm_sts_t;

endpackage

// File: hw/rtl/kwhm_if.sv
// Input and output channel interfaces of the heap merger.
interface kwhm_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         cmd;
  logic signed [kwhm_pkg::VAL_W-1:0]  new_value;
  modport source (output valid, cmd, new_value, input ready);
  modport sink (input valid, cmd, new_value, output ready);
endinterface

interface kwhm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [kwhm_pkg::VAL_W-1:0]  out_value;
  logic                               out_valid;
  logic                               out_last;
  logic                               overflow;
  modport source (output valid, out_value, out_valid, out_last, overflow, input ready);
  modport sink (input valid, out_value, out_valid, out_last, overflow, output ready);
endinterface

// File: hw/rtl/kway_heap_merge.sv
// Top level of the k-way heap merger: controller, datapath and checks.
// Loads (append, open) give no item; pops give one item each.
// A pop reads the root, steps its list pointer, then sifts the new root down one heap level at a
// time and places it; a pop on an empty heap gives an item without a value.
// The heap memory has one write and one registered read and serves one read per cycle, which sets the cost of a level.
// The first pop after loading also builds the heap: one sift for each of the first
// list_total/2 heap slots, from the last of them back to the root.
// The next item is taken once the pop result is in the output register; loads go on while it waits.
module kway_heap_merge #(
  parameter int unsigned MAX_LISTS = kwhm_pkg::MAX_LISTS_DEF,
  parameter int unsigned MAX_ITEMS = kwhm_pkg::MAX_ITEMS_DEF
) (
  input logic       clk,
  input logic       rst,
  kwhm_in_if.sink   in_ch,
  kwhm_out_if.source out_ch
);
  import kwhm_pkg::*;

  kwhm_ctl_t ctl;
  kwhm_sts_t sts;

  kwhm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  kwhm_dp #(
    .MAX_LISTS (MAX_LISTS),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .in_cmd         (in_ch.cmd),
    .in_value       (in_ch.new_value),
    .ctl            (ctl),
    .sts            (sts),
    .out_ready      (out_ch.ready),
    .out_item_valid (out_ch.valid),
    .out_value      (out_ch.out_value),
    .out_valid      (out_ch.out_valid),
    .out_last       (out_ch.out_last),
    .overflow       (out_ch.overflow)
  );

  a_last_has_value: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (!out_ch.out_last || out_ch.out_valid))
    else $error("last flag on an item without a value");

  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && in_ch.cmd == CMD_POP |=> !in_ch.ready)
    else $error("new item taken while a pop is in progress");

  a_empty_pop_value: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.out_valid |-> out_ch.out_value == '0)
    else $error("empty pop carries a nonzero value");

endmodule

// File: hw/rtl/kwhm_dp.sv
// Datapath of the heap merger: item store, list pointers, heap memory and result register.
module kwhm_dp #(
  parameter int unsigned MAX_LISTS = kwhm_pkg::MAX_LISTS_DEF,
  parameter int unsigned MAX_ITEMS = kwhm_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        in_cmd,
  input  logic signed [kwhm_pkg::VAL_W-1:0] in_value,
  input  kwhm_pkg::kwhm_ctl_t               ctl,
  output kwhm_pkg::kwhm_sts_t               sts,
  input  logic                              out_ready,
  output logic                              out_item_valid,
  output logic signed [kwhm_pkg::VAL_W-1:0] out_value,
  output logic                              out_valid,
  output logic                              out_last,
  output logic                              overflow
);
  import kwhm_pkg::*;

  localparam int unsigned LW  = $clog2(MAX_LISTS);
  localparam int unsigned IW  = $clog2(MAX_ITEMS);
  localparam int unsigned LCW = $clog2(MAX_LISTS + 1);
  localparam int unsigned ICW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned PW  = LCW + 1;

  typedef struct packed {
    logic [LW-1:0]           lst;
    logic signed [VAL_W-1:0] key;
  } ent_t;

  ent_t                    heap_mem [MAX_LISTS];
  logic [VAL_W-1:0]        store_mem [MAX_ITEMS];
  logic [IW-1:0]           rp_mem [MAX_LISTS];
  logic [ICW-1:0]          end_mem [MAX_LISTS];

  ent_t                    heap_q;
  logic [VAL_W-1:0]        store_q;
  logic [IW-1:0]           rp_q;
  logic [ICW-1:0]          end_q;

  logic [LCW-1:0]          list_total;
  logic [ICW-1:0]          item_total;
  logic [LCW-1:0]          heap_fill;
  logic [LCW-1:0]          build_s;
  logic                    merging;
  logic                    dropped;
  logic                    discarding;
  logic                    hit;
  logic [PW-1:0]           pos;
  logic [PW-1:0]           best;
  ent_t                    cur;
  ent_t                    bestent;
  ent_t                    root;

  logic [LCW-1:0]          lt_eff;
  logic [ICW-1:0]          it_eff;
  logic                    disc_eff;
  logic                    do_open;
  logic                    open_ok;
  logic                    app_ok;
  logic [LW-1:0]           end_wa;
  logic [IW:0]             inc;
  logic                    list_empty;
  logic [PW:0]             lch;
  logic [PW:0]             rch;
  logic [PW:0]             fill_x;
  logic [PW-1:0]           pos_m1;
  logic                    heap_re;
  logic [LW-1:0]           heap_ra;
  logic                    best_is_pos;

  always_comb begin
    lt_eff   = merging ? '0 : list_total;
    it_eff   = merging ? '0 : item_total;
    disc_eff = merging ? 1'b0 : discarding;
    do_open  = (in_cmd == CMD_OPEN) ||
               (in_cmd == CMD_APPEND && !disc_eff && lt_eff == '0);
    open_ok  = do_open && (lt_eff < LCW'(MAX_LISTS)) && (it_eff < ICW'(MAX_ITEMS));
    app_ok   = !do_open && (in_cmd == CMD_APPEND) && !disc_eff &&
               (it_eff < ICW'(MAX_ITEMS));
    end_wa   = do_open ? lt_eff[LW-1:0] : LW'(lt_eff - 1'b1);
    inc      = {1'b0, rp_q} + 1'b1;
    list_empty = (inc == (IW+1)'(end_q)) || (inc == (IW+1)'(MAX_ITEMS));
    lch      = {pos, 1'b0};
    rch      = lch + 1'b1;
    fill_x   = (PW+1)'(heap_fill);
    pos_m1   = pos - 1'b1;
    best_is_pos = (best == pos);
  end

  always_comb begin
    heap_re = 1'b0;
    heap_ra = '0;
    if (ctl.build_rd) begin
      heap_re = 1'b1;
      heap_ra = LW'(build_s - 1'b1);
    end else if (ctl.root_rd) begin
      heap_re = 1'b1;
    end else if (ctl.ptr_step) begin
      heap_re = list_empty;
      heap_ra = LW'(heap_fill - 1'b1);
    end else if (ctl.sift_rd_l) begin
      heap_re = !(lch > fill_x);
      heap_ra = LW'(lch - 1'b1);
    end else if (ctl.sift_cap_l) begin
      heap_re = !(rch > fill_x);
      heap_ra = LW'(lch);
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (ctl.load && open_ok) begin
      heap_mem[lt_eff[LW-1:0]] <= '{lst: lt_eff[LW-1:0], key: in_value};
    end else if (ctl.sift_wr) begin
      heap_mem[pos_m1[LW-1:0]] <= best_is_pos ? cur : bestent;
    end
    if (heap_re) begin
      heap_q <= heap_mem[heap_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && (open_ok || app_ok)) begin
      store_mem[it_eff[IW-1:0]] <= in_value;
      end_mem[end_wa] <= it_eff + 1'b1;
    end
    if (ctl.ptr_step && !list_empty) begin
      store_q <= store_mem[inc[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && open_ok) begin
      rp_mem[lt_eff[LW-1:0]] <= it_eff[IW-1:0];
    end else if (ctl.ptr_step && !list_empty) begin
      rp_mem[root.lst] <= inc[IW-1:0];
    end
    if (ctl.root_cap) begin
      rp_q  <= rp_mem[heap_q.lst];
      end_q <= end_mem[heap_q.lst];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      list_total     <= '0;
      item_total     <= '0;
      heap_fill      <= '0;
      build_s        <= '0;
      merging        <= 1'b0;
      dropped        <= 1'b0;
      discarding     <= 1'b0;
      hit            <= 1'b0;
      out_item_valid <= 1'b0;
    end else begin
      if (ctl.load) begin
        merging <= 1'b0;
        if (merging) begin
          heap_fill <= '0;
        end
        if (open_ok) begin
          list_total <= lt_eff + 1'b1;
          item_total <= it_eff + 1'b1;
          discarding <= 1'b0;
        end else if (app_ok) begin
          list_total <= lt_eff;
          item_total <= it_eff + 1'b1;
          discarding <= 1'b0;
        end else begin
          list_total <= lt_eff;
          item_total <= it_eff;
          dropped    <= 1'b1;
          discarding <= do_open ? 1'b1 : disc_eff;
        end
      end
      if (ctl.start) begin
        hit <= 1'b0;
        if (!merging) begin
          merging   <= 1'b1;
          heap_fill <= list_total;
          build_s   <= list_total >> 1;
        end
      end
      if (ctl.build_cap) begin
        build_s <= build_s - 1'b1;
      end
      if (ctl.root_cap) begin
        hit <= 1'b1;
      end
      if (ctl.last_cap) begin
        heap_fill <= heap_fill - 1'b1;
      end
      if (ctl.res_load) begin
        out_item_valid <= 1'b1;
      end else if (out_ready) begin
        out_item_valid <= 1'b0;
      end
    end
  end

  // sift registers and result payload
  always_ff @(posedge clk) begin
    if (ctl.build_cap) begin
      cur <= heap_q;
      pos <= PW'(build_s);
    end
    if (ctl.root_cap) begin
      root <= heap_q;
    end
    if (ctl.key_cap) begin
      cur <= '{lst: root.lst, key: store_q};
      pos <= PW'(1);
    end
    if (ctl.last_cap) begin
      cur <= heap_q;
      pos <= PW'(1);
    end
    if (ctl.sift_rd_l) begin
      best    <= pos;
      bestent <= cur;
    end
    if (ctl.sift_cap_l && (heap_q.key < cur.key)) begin
      best    <= lch[PW-1:0];
      bestent <= heap_q;
    end
    if (ctl.sift_cap_r && (heap_q.key < bestent.key)) begin
      best    <= rch[PW-1:0];
      bestent <= heap_q;
    end
    if (ctl.sift_wr && !best_is_pos) begin
      pos <= best;
    end
    if (ctl.res_load) begin
      out_value <= hit ? root.key : '0;
      out_valid <= hit;
      out_last  <= hit && (heap_fill == '0);
      overflow  <= dropped;
    end
  end

  always_comb begin
    sts.merging     = merging;
    sts.fill_zero   = (heap_fill == '0);
    sts.build_done  = (build_s == '0);
    sts.list_empty  = list_empty;
    sts.pos_out     = (PW+1)'(pos) > fill_x;
    sts.leaf        = lch > fill_x;
    sts.no_right    = rch > fill_x;
    sts.best_is_pos = best_is_pos;
    sts.out_free    = !out_item_valid || out_ready;
  end

endmodule

// File: hw/rtl/kwhm_ctrl.sv
// Controller state machine of the heap merger: load, heap build, pop and sift sequencing.
module kwhm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_ready,
  input  kwhm_pkg::kwhm_sts_t sts,
  output kwhm_pkg::kwhm_ctl_t ctl
);
  import kwhm_pkg::*;

  typedef enum logic [12:0] {
    IDLE    = 13'b0000000000001,
    B_NEXT  = 13'b0000000000010,
    B_CAP   = 13'b0000000000100,
    P_RD    = 13'b0000000001000,
    P_ROOT  = 13'b0000000010000,
    P_PTR   = 13'b0000000100000,
    P_KEY   = 13'b0000001000000,
    P_LAST  = 13'b0000010000000,
    S_LEFT  = 13'b0000100000000,
    S_CAPL  = 13'b0001000000000,
    S_CAPR  = 13'b0010000000000,
    S_WRITE = 13'b0100000000000,
    FINISH  = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   building, building_next;
  state_t after_sift;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      building <= 1'b0;
    end else begin
      state    <= state_next;
      building <= building_next;
    end
  end

  assign after_sift = building ? B_NEXT : FINISH;

  always_comb begin
    state_next    = state;
    building_next = building;
    ctl           = '0;
    in_ready      = 1'b0;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_APPEND || in_cmd == CMD_OPEN) begin
            ctl.load = 1'b1;
          end else if (in_cmd == CMD_POP) begin
            ctl.start = 1'b1;
            building_next = !sts.merging;
            state_next = sts.merging ? P_RD : B_NEXT;
          end
        end
      end
      B_NEXT: begin
        if (sts.build_done) begin
          building_next = 1'b0;
          state_next = P_RD;
        end else begin
          ctl.build_rd = 1'b1;
          state_next = B_CAP;
        end
      end
      B_CAP: begin
        ctl.build_cap = 1'b1;
        state_next = S_LEFT;
      end
      P_RD: begin
        if (sts.fill_zero) begin
          state_next = FINISH;
        end else begin
          ctl.root_rd = 1'b1;
          state_next = P_ROOT;
        end
      end
      P_ROOT: begin
        ctl.root_cap = 1'b1;
        state_next = P_PTR;
      end
      P_PTR: begin
        ctl.ptr_step = 1'b1;
        state_next = sts.list_empty ? P_LAST : P_KEY;
      end
      P_KEY: begin
        ctl.key_cap = 1'b1;
        state_next = S_LEFT;
      end
      P_LAST: begin
        ctl.last_cap = 1'b1;
        state_next = S_LEFT;
      end
      S_LEFT: begin
        if (sts.pos_out) begin
          state_next = after_sift;
        end else begin
          ctl.sift_rd_l = 1'b1;
          state_next = sts.leaf ? S_WRITE : S_CAPL;
        end
      end
      S_CAPL: begin
        ctl.sift_cap_l = 1'b1;
        state_next = sts.no_right ? S_WRITE : S_CAPR;
      end
      S_CAPR: begin
        ctl.sift_cap_r = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        ctl.sift_wr = 1'b1;
        state_next = sts.best_is_pos ? after_sift : S_LEFT;
      end
      FINISH: begin
        if (sts.out_free) begin
          ctl.res_load = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule
